// ===== hdl/wpm_pkg.sv =====
// Shared types, widths and register indexes for the weighted pixel mixer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package wpm_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_SOURCES_DEF    = 4;
    localparam int INTENSITY_BITS_DEF = 5;
    localparam int QUEUE_DEPTH_DEF    = 2;

    // Fixed field widths.
    localparam int LANES       = 4;
    localparam int NUM_FACTORS = 4;
    localparam int FSEL_W      = 2;
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 32;
    localparam int FACTOR_W    = 14;
    localparam int COUNT_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 14;
    localparam int QUOT_W      = 8;

    // Scale is channel a times a factor: 9-bit signed by 14-bit signed, fits 22 bits.
    localparam int SCALE_W = 22;
    // Lane product is a channel times the scale.
    localparam int LPROD_W = CHAN_W + 1 + SCALE_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR3 = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0]         COUNT_RESET  = 3'd1;
    localparam logic signed [FACTOR_W-1:0] FACTOR_RESET = 14'sd256;

    // One finished pixel's accumulated sums, handed from front to back.
    typedef struct packed {
        logic                            intensity;
        logic [LANES-1:0][SUM_W-1:0]     sums;
    } wpm_job_t;

endpackage

`default_nettype wire

// ===== hdl/wpm_front.sv =====
// Front end: configuration registers, source sequencing and multiply-accumulate.
// Depends on wpm_pkg; pushes finished sums into wpm_queue.
`timescale 1ns / 1ps
`default_nettype none

module wpm_front #(
    parameter int MAX_SOURCES = wpm_pkg::MAX_SOURCES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [wpm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [wpm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [wpm_pkg::CHAN_W-1:0]           chan_a,
    input  wire logic [wpm_pkg::CHAN_W-1:0]           chan_b,
    input  wire logic [wpm_pkg::CHAN_W-1:0]           chan_c,
    input  wire logic [wpm_pkg::CHAN_W-1:0]           chan_d,
    output logic                                      push,
    output wpm_pkg::wpm_job_t                         job,
    input  wire logic                                 full
);

    localparam int SRC_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CNT_W = SRC_W + 1;
    localparam int CMP_W = (CNT_W > wpm_pkg::COUNT_W) ? CNT_W : wpm_pkg::COUNT_W;
    localparam int LANES   = wpm_pkg::LANES;
    localparam int SUM_W   = wpm_pkg::SUM_W;
    localparam int CHAN_W  = wpm_pkg::CHAN_W;
    localparam int SCALE_W = wpm_pkg::SCALE_W;
    localparam int LPROD_W = wpm_pkg::LPROD_W;
    localparam int FACT_W  = wpm_pkg::FACTOR_W;

    logic                           mode_reg;
    logic [wpm_pkg::COUNT_W-1:0]    count_reg;
    logic signed [FACT_W-1:0]       factor_reg [wpm_pkg::NUM_FACTORS];
    logic [SRC_W-1:0]               idx_reg;
    logic [SRC_W-1:0]               idx_next;
    logic                           pend_reg;
    logic                           pend_mode_reg;
    logic                           pend_last_reg;
    logic [CHAN_W-1:0]              ch_reg [LANES];
    logic signed [SCALE_W-1:0]      scale_reg;
    logic signed [SCALE_W-1:0]      scale_next;
    logic [SUM_W-1:0]               sums_reg [LANES];
    logic [SUM_W-1:0]               sums_add [LANES];

    logic [CHAN_W-1:0]              ch_in [LANES];
    logic [CMP_W-1:0]               count_ext;
    logic [CMP_W-1:0]               cnt_eff;
    logic [CMP_W-1:0]               idx_inc;
    logic                           last;
    logic [wpm_pkg::FSEL_W-1:0]     fsel;
    logic signed [FACT_W-1:0]       fac;
    logic signed [SCALE_W:0]        prod_a;
    logic signed [LPROD_W-1:0]      lane_prod [LANES];
    logic                           accept;
    logic                           done;

    assign ch_in[0] = chan_a;
    assign ch_in[1] = chan_b;
    assign ch_in[2] = chan_c;
    assign ch_in[3] = chan_d;

    // One item in flight: accepted, then accumulated; a pixel's last item waits on full.
    assign in_stall = pend_reg;
    assign accept   = in_valid && !pend_reg;

    always_comb
    begin
        count_ext = CMP_W'(count_reg);
        cnt_eff   = count_ext;
        if (count_ext == '0)
        begin
            cnt_eff = CMP_W'(1);
        end
        else if (count_ext > CMP_W'(MAX_SOURCES))
        begin
            cnt_eff = CMP_W'(MAX_SOURCES);
        end
        idx_inc  = CMP_W'(idx_reg) + CMP_W'(1);
        last     = (idx_inc >= cnt_eff);
        idx_next = last ? '0 : SRC_W'(idx_inc);
        fsel     = wpm_pkg::FSEL_W'(idx_reg);
        fac      = factor_reg[fsel];
        prod_a   = $signed({1'b0, chan_a}) * fac;
        if (mode_reg)
        begin
            scale_next = prod_a[SCALE_W-1:0];
        end
        else
        begin
            scale_next = {{(SCALE_W - FACT_W){fac[FACT_W-1]}}, fac};
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lane_prod[i] = $signed({1'b0, ch_reg[i]}) * scale_reg;
            // In intensity mode channel a is a weight, not a colour, and is not summed.
            if (pend_mode_reg && (i == 0))
            begin
                sums_add[i] = sums_reg[i];
            end
            else
            begin
                sums_add[i] = sums_reg[i]
                    + {{(SUM_W - LPROD_W){lane_prod[i][LPROD_W-1]}}, lane_prod[i]};
            end
        end
    end

    assign done = pend_reg && (!pend_last_reg || !full);
    assign push = pend_reg && pend_last_reg && !full;

    always_comb
    begin
        job.intensity = pend_mode_reg;
        for (int i = 0; i < LANES; i++)
        begin
            job.sums[i] = sums_add[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= wpm_pkg::COUNT_RESET;
            for (int i = 0; i < wpm_pkg::NUM_FACTORS; i++)
            begin
                factor_reg[i] <= wpm_pkg::FACTOR_RESET;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                wpm_pkg::REG_MODE:    mode_reg      <= cfg_data[0];
                wpm_pkg::REG_COUNT:   count_reg     <= cfg_data[wpm_pkg::COUNT_W-1:0];
                wpm_pkg::REG_FACTOR0: factor_reg[0] <= $signed(cfg_data);
                wpm_pkg::REG_FACTOR1: factor_reg[1] <= $signed(cfg_data);
                wpm_pkg::REG_FACTOR2: factor_reg[2] <= $signed(cfg_data);
                wpm_pkg::REG_FACTOR3: factor_reg[3] <= $signed(cfg_data);
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                idx_reg       <= idx_next;
                pend_reg      <= 1'b1;
                pend_last_reg <= last;
            end
            else if (done)
            begin
                pend_reg <= 1'b0;
            end
            if (done)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    sums_reg[i] <= pend_last_reg ? '0 : sums_add[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_mode_reg <= mode_reg;
            scale_reg     <= scale_next;
            for (int i = 0; i < LANES; i++)
            begin
                ch_reg[i] <= ch_in[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wpm_queue.sv =====
// Short first-in first-out queue of finished sums between front and back.
// Depends on wpm_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module wpm_queue #(
    parameter int DEPTH = wpm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire wpm_pkg::wpm_job_t  push_job,
    output logic                    full,
    input  wire logic               pop,
    output wpm_pkg::wpm_job_t       pop_job,
    output logic                    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wpm_pkg::wpm_job_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wpm_back.sv =====
// Back end: global intensity pick, rounding, 8-step restoring divide and clamp.
// Depends on wpm_pkg; pops finished sums from wpm_queue.
`timescale 1ns / 1ps
`default_nettype none

module wpm_back #(
    parameter int INTENSITY_BITS = wpm_pkg::INTENSITY_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_empty,
    output logic                              q_pop,
    input  wire wpm_pkg::wpm_job_t            q_job,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [wpm_pkg::CHAN_W-1:0]        mix_a,
    output logic [wpm_pkg::CHAN_W-1:0]        mix_b,
    output logic [wpm_pkg::CHAN_W-1:0]        mix_c,
    output logic [wpm_pkg::CHAN_W-1:0]        mix_d
);

    localparam int IB      = INTENSITY_BITS;
    localparam int LANES   = wpm_pkg::LANES;
    localparam int SUM_W   = wpm_pkg::SUM_W;
    localparam int QUOT_W  = wpm_pkg::QUOT_W;
    localparam int N_W     = SUM_W + 1;
    localparam int HI_W    = N_W - 8;
    localparam int DIV_W   = IB + QUOT_W;
    localparam int STEP_W  = $clog2(QUOT_W);
    localparam logic [IB-1:0]    G_MAX    = IB'((1 << IB) - 1);
    localparam logic [SUM_W-1:0] G_TOP    = SUM_W'(((1 << IB) - 1) << 16);
    localparam logic [SUM_W-1:0] G_ONE_UP = SUM_W'(1 << 16);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_PREP = 5'b00010,
        B_LOAD = 5'b00100,
        B_DIV  = 5'b01000,
        B_OUT  = 5'b10000
    } wpm_bstate_t;

    wpm_bstate_t        state_reg;
    wpm_bstate_t        state_next;
    wpm_pkg::wpm_job_t  job_reg;
    logic [IB-1:0]      g_reg;
    logic [IB-1:0]      g_next;
    logic               zero_reg;
    logic [DIV_W-1:0]   dsh_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [HI_W-1:0]    rem_reg [LANES];
    logic [QUOT_W-1:0]  q_reg [LANES];
    logic               skip_reg [LANES];

    logic [SUM_W-1:0]   m12;
    logic [SUM_W-1:0]   m_max;
    logic               raw;
    logic [IB-1:0]      divisor;
    logic [N_W-1:0]     offset;
    logic [N_W-1:0]     n_val [LANES];
    logic [HI_W-1:0]    hi_val [LANES];
    logic               nonpos [LANES];
    logic               sat [LANES];

    // Largest colour sum, compared as unsigned, picks the global intensity.
    always_comb
    begin
        m12   = (job_reg.sums[1] > job_reg.sums[2]) ? job_reg.sums[1] : job_reg.sums[2];
        m_max = (m12 > job_reg.sums[3]) ? m12 : job_reg.sums[3];
        if (m_max <= G_ONE_UP)
        begin
            g_next = IB'(1);
        end
        else if (m_max >= G_TOP)
        begin
            g_next = G_MAX;
        end
        else
        begin
            g_next = IB'((m_max >> 16) + SUM_W'(1));
        end
    end

    // A divide by 256*g (g is 1 in raw mode) is a shift by eight and then a divide by g;
    // a sum that rounds to zero or below clamps to zero and one whose quotient reaches 256 saturates.
    always_comb
    begin
        raw     = !job_reg.intensity;
        divisor = raw ? IB'(1) : g_reg;
        offset  = raw ? N_W'(128) : (N_W'({g_reg, 8'b0}) - N_W'(127));
        for (int i = 0; i < LANES; i++)
        begin
            n_val[i]  = {job_reg.sums[i][SUM_W-1], job_reg.sums[i]} + offset;
            nonpos[i] = n_val[i][N_W-1] || (n_val[i] == '0);
            hi_val[i] = n_val[i][N_W-1:8];
            sat[i]    = (hi_val[i] >= HI_W'({divisor, 8'b0}));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = B_PREP;
                end
            end
            B_PREP: state_next = B_LOAD;
            B_LOAD: state_next = B_DIV;
            B_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    job_reg <= q_job;
                end
            end
            B_PREP:
            begin
                g_reg    <= g_next;
                zero_reg <= (m_max == '0);
            end
            B_LOAD:
            begin
                dsh_reg  <= DIV_W'(divisor) << (QUOT_W - 1);
                step_reg <= STEP_W'(QUOT_W - 1);
                for (int i = 0; i < LANES; i++)
                begin
                    rem_reg[i]  <= hi_val[i];
                    skip_reg[i] <= nonpos[i] || sat[i];
                    q_reg[i]    <= (!nonpos[i] && sat[i]) ? '1 : '0;
                end
            end
            B_DIV:
            begin
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg - STEP_W'(1);
                for (int i = 0; i < LANES; i++)
                begin
                    if (!skip_reg[i])
                    begin
                        if (rem_reg[i] >= HI_W'(dsh_reg))
                        begin
                            rem_reg[i] <= rem_reg[i] - HI_W'(dsh_reg);
                            q_reg[i]   <= {q_reg[i][QUOT_W-2:0], 1'b1};
                        end
                        else
                        begin
                            q_reg[i] <= {q_reg[i][QUOT_W-2:0], 1'b0};
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_valid = (state_reg == B_OUT);
    assign mix_a = job_reg.intensity ? (zero_reg ? '0 : wpm_pkg::CHAN_W'(g_reg)) : q_reg[0];
    assign mix_b = q_reg[1];
    assign mix_c = q_reg[2];
    assign mix_d = q_reg[3];

endmodule

`default_nettype wire

// ===== hdl/weighted_pixel_mix.sv =====
// Top level of the weighted pixel mixer: front end, sums queue and back end.
// Depends on wpm_pkg, wpm_front, wpm_queue and wpm_back.
//
//  Channel  Handshake              Payload
//  in       in_valid / in_stall    chan_a, chan_b, chan_c, chan_d (8 bits each)
//  out      out_valid / out_stall  mix_a, mix_b, mix_c, mix_d (8 bits each)
//  cfg      cfg_write              cfg_index (3 bits), cfg_data (14 bits)
//
// The front end takes one source item at a time: it registers the item and its scale
// product, then multiply-accumulates the channels (a to d in raw mode, b to d in
// intensity mode). Each output pixel then passes through the back end in order: pop,
// intensity pick, setup, 8 steps of restoring divide and output. The queue holds
// QUEUE_DEPTH finished pixels, so until it is full the front keeps taking items while
// the back end divides or the output is stalled. Reset is asynchronous, active low.
`timescale 1ns / 1ps
`default_nettype none

module weighted_pixel_mix #(
    parameter int MAX_SOURCES    = wpm_pkg::MAX_SOURCES_DEF,
    parameter int INTENSITY_BITS = wpm_pkg::INTENSITY_BITS_DEF,
    parameter int QUEUE_DEPTH    = wpm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [wpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wpm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [wpm_pkg::CHAN_W-1:0]       chan_a,
    input  wire logic [wpm_pkg::CHAN_W-1:0]       chan_b,
    input  wire logic [wpm_pkg::CHAN_W-1:0]       chan_c,
    input  wire logic [wpm_pkg::CHAN_W-1:0]       chan_d,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [wpm_pkg::CHAN_W-1:0]            mix_a,
    output logic [wpm_pkg::CHAN_W-1:0]            mix_b,
    output logic [wpm_pkg::CHAN_W-1:0]            mix_c,
    output logic [wpm_pkg::CHAN_W-1:0]            mix_d
);

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    wpm_pkg::wpm_job_t  push_job;
    wpm_pkg::wpm_job_t  pop_job;

    wpm_front #(
        .MAX_SOURCES (MAX_SOURCES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .chan_a    (chan_a),
        .chan_b    (chan_b),
        .chan_c    (chan_c),
        .chan_d    (chan_d),
        .push      (q_push),
        .job       (push_job),
        .full      (q_full)
    );

    wpm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    wpm_back #(
        .INTENSITY_BITS (INTENSITY_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_job     (pop_job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mix_a     (mix_a),
        .mix_b     (mix_b),
        .mix_c     (mix_c),
        .mix_d     (mix_d)
    );

`ifndef ASSERT_OFF
    // The front end never pushes a finished pixel into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("sums queue overflow");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("sums queue underflow");

    // An accepted item holds the front end for its accumulate cycle.
    a_accum_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("front end took a second item before accumulating the first");

    // A result is never shown in the cycle right after a pop.
    a_back_latency: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !out_valid)
        else $error("back end produced a result without dividing");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/weighted_pixel_mix_tb.sv =====
// Self-checking testbench for weighted_pixel_mix: directed and random source items,
// register settings, input gaps and output stalls, with a scoreboard that predicts each pixel.
// Depends on wpm_pkg and the weighted_pixel_mix RTL.
`timescale 1ns / 1ps

module weighted_pixel_mix_tb;

    import wpm_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int IDLE_PCT      = 37;
    // Room for the front end to finish a partial item before a register write.
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 40;

    localparam bit MODE_RAW       = 1'b0;
    localparam bit MODE_INTENSITY = 1'b1;

    localparam int MAX_GAIN = (1 << INTENSITY_BITS_DEF) - 1;

    typedef struct packed {
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] c;
        logic [CHAN_W-1:0] d;
    } pixel_t;

    class mix_scoreboard;
        bit                           mode;
        logic [COUNT_W-1:0]           count;
        logic signed [FACTOR_W-1:0]   factor [NUM_FACTORS];
        logic [SUM_W-1:0]             sums [LANES];
        logic [1:0]                   src_idx;
        pixel_t                       expected_pixels [$];
        int                           errors;
        int                           pixels_checked;
        int                           intensity_pixels;
        int                           sources_taken;

        function new();
            mode = MODE_RAW;
            count = COUNT_RESET;
            for (int i = 0; i < NUM_FACTORS; i++)
                factor[i] = FACTOR_RESET;
            for (int i = 0; i < LANES; i++)
                sums[i] = '0;
            src_idx = '0;
            errors = 0;
            pixels_checked = 0;
            intensity_pixels = 0;
            sources_taken = 0;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MODE:  mode = data[0];
                REG_COUNT: count = data[COUNT_W-1:0];
                REG_FACTOR0, REG_FACTOR1, REG_FACTOR2, REG_FACTOR3:
                    factor[idx - REG_FACTOR0] = data;
                default: ;
            endcase
        endfunction

        function logic [CHAN_W-1:0] clamp8(longint v);
            if (v < 0)
                return 8'd0;
            if (v > 255)
                return 8'd255;
            return v[CHAN_W-1:0];
        endfunction

        // Accumulate one accepted source item; a finished pixel joins the queue.
        function void note_source(pixel_t px);
            logic [CHAN_W-1:0] ch [LANES];
            longint            prod;
            longint            div;
            int                eff_count;
            logic [SUM_W-1:0]  peak;
            int unsigned       gain;
            logic [CHAN_W-1:0] res [LANES];
            pixel_t            want;

            ch[0] = px.a;
            ch[1] = px.b;
            ch[2] = px.c;
            ch[3] = px.d;
            sources_taken++;
            eff_count = (count == 0) ? 1 :
                        (count > MAX_SOURCES_DEF) ? MAX_SOURCES_DEF : int'(count);

            if (mode == MODE_INTENSITY) begin
                for (int i = 1; i < LANES; i++) begin
                    prod = longint'(ch[i]) * longint'(ch[0]) * longint'(factor[src_idx]);
                    sums[i] = sums[i] + prod[SUM_W-1:0];
                end
            end else begin
                for (int i = 0; i < LANES; i++) begin
                    prod = longint'(ch[i]) * longint'(factor[src_idx]);
                    sums[i] = sums[i] + prod[SUM_W-1:0];
                end
            end

            if (int'(src_idx) + 1 < eff_count) begin
                src_idx = src_idx + 2'd1;
                return;
            end

            if (mode == MODE_INTENSITY) begin
                // Negative sums compare as large unsigned values here.
                peak = '0;
                for (int i = 1; i < LANES; i++)
                    if (sums[i] > peak)
                        peak = sums[i];
                if (peak == 0) begin
                    for (int i = 0; i < LANES; i++)
                        res[i] = '0;
                end else begin
                    if (peak <= 32'd65536)
                        gain = 1;
                    else if (peak >= (32'(MAX_GAIN) << 16))
                        gain = MAX_GAIN;
                    else
                        gain = (peak >> 16) + 1;
                    div = 256 * longint'(gain);
                    res[0] = gain[CHAN_W-1:0];
                    for (int i = 1; i < LANES; i++)
                        res[i] = clamp8((longint'(signed'(sums[i])) + div - 127) / div);
                end
                intensity_pixels++;
            end else begin
                for (int i = 0; i < LANES; i++)
                    res[i] = clamp8((longint'(signed'(sums[i])) + 128) / 256);
            end

            want.a = res[0];
            want.b = res[1];
            want.c = res[2];
            want.d = res[3];
            expected_pixels.push_back(want);
            for (int i = 0; i < LANES; i++)
                sums[i] = '0;
            src_idx = '0;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(pixel_t got);
            pixel_t want;

            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel %h with none expected", got));
                return;
            end
            want = expected_pixels.pop_front();
            if (got.a !== want.a)
                report_mismatch($sformatf("pixel %0d mix_a got %0d want %0d",
                                          pixels_checked, got.a, want.a));
            if (got.b !== want.b)
                report_mismatch($sformatf("pixel %0d mix_b got %0d want %0d",
                                          pixels_checked, got.b, want.b));
            if (got.c !== want.c)
                report_mismatch($sformatf("pixel %0d mix_c got %0d want %0d",
                                          pixels_checked, got.c, want.c));
            if (got.d !== want.d)
                report_mismatch($sformatf("pixel %0d mix_d got %0d want %0d",
                                          pixels_checked, got.d, want.d));
            pixels_checked++;
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [CHAN_W-1:0]     chan_a;
    logic [CHAN_W-1:0]     chan_b;
    logic [CHAN_W-1:0]     chan_c;
    logic [CHAN_W-1:0]     chan_d;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CHAN_W-1:0]     mix_a;
    logic [CHAN_W-1:0]     mix_b;
    logic [CHAN_W-1:0]     mix_c;
    logic [CHAN_W-1:0]     mix_d;

    mix_scoreboard sb = new();
    bit            no_idle = 1'b0;
    int            idle_cycles = 0;
    int            reg_writes = 0;
    int            settings_used = 0;

    weighted_pixel_mix dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .chan_a    (chan_a),
        .chan_b    (chan_b),
        .chan_c    (chan_c),
        .chan_d    (chan_d),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mix_a     (mix_a),
        .mix_b     (mix_b),
        .mix_c     (mix_c),
        .mix_d     (mix_d)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({mix_a, mix_b, mix_c, mix_d});
    end

    // Ends the run when neither channel has moved an item for too long.
    initial
    begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout after %0d cycles without progress", STALL_LIMIT);
        $display("weighted_pixel_mix_tb: FAIL");
        $finish;
    end

    function automatic pixel_t mk_pixel(int a, int b, int c, int d);
        pixel_t px;
        px.a = a[CHAN_W-1:0];
        px.b = b[CHAN_W-1:0];
        px.c = c[CHAN_W-1:0];
        px.d = d[CHAN_W-1:0];
        return px;
    endfunction

    function automatic logic [CHAN_W-1:0] random_chan();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic signed [FACTOR_W-1:0] random_factor();
        int picks [6] = '{-8192, 8191, -4096, 4096, 0, 256};
        case ($urandom_range(0, 3))
            0:       return FACTOR_W'($urandom());
            3:       return FACTOR_W'(picks[$urandom_range(0, 5)]);
            default: return FACTOR_W'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(pixel_t px);
        while (!no_idle && ($urandom_range(0, 99) < IDLE_PCT)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        chan_a <= px.a;
        chan_b <= px.b;
        chan_c <= px.c;
        chan_d <= px.d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_source(px);
        @(negedge clk);
    endtask

    task automatic send_random(int n);
        repeat (n)
            send_item({random_chan(), random_chan(), random_chan(), random_chan()});
    endtask

    // Holds the sender until every pixel is out and the front end has gone quiet.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_config(bit m, logic [COUNT_W-1:0] n,
                               logic signed [FACTOR_W-1:0] f0, logic signed [FACTOR_W-1:0] f1,
                               logic signed [FACTOR_W-1:0] f2, logic signed [FACTOR_W-1:0] f3);
        drain_and_settle();
        write_cfg(REG_MODE, CFG_DATA_W'(m));
        write_cfg(REG_COUNT, CFG_DATA_W'(n));
        write_cfg(REG_FACTOR0, f0);
        write_cfg(REG_FACTOR1, f1);
        write_cfg(REG_FACTOR2, f2);
        write_cfg(REG_FACTOR3, f3);
        settings_used++;
    endtask

    initial
    begin
        int phase;
        int sent;
        int n;

        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        chan_a    = '0;
        chan_b    = '0;
        chan_c    = '0;
        chan_d    = '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: raw mode, one source at full weight.
        send_item(mk_pixel(0, 0, 0, 0));
        send_item(mk_pixel(255, 255, 255, 255));
        send_item(mk_pixel(8'h55, 8'hAA, 8'h0F, 8'hF0));

        // Largest nominal weights, positive and negative, in one pixel whose sums saturate high.
        load_config(MODE_RAW, 3'd2, 4096, -4096, 0, 0);
        send_item(mk_pixel(255, 255, 255, 255));
        send_item(mk_pixel(1, 2, 3, 4));

        // A count of zero acts as one; weights outside the nominal range.
        load_config(MODE_RAW, 3'd0, -8192, 8191, 256, 256);
        send_item(mk_pixel(200, 100, 50, 1));

        // A count above the source limit acts as the limit.
        load_config(MODE_RAW, 3'd7, 8191, -8192, 8191, 128);
        send_item(mk_pixel(255, 0, 8'hAA, 8'h55));
        send_item(mk_pixel(0, 255, 8'h55, 8'hAA));
        send_item(mk_pixel(255, 255, 0, 0));
        send_item(mk_pixel(128, 127, 1, 254));

        // Intensity mode: zero peak, peak just below the top, top gain and unity gain.
        load_config(MODE_INTENSITY, 3'd1, 256, 256, 256, 256);
        send_item(mk_pixel(0, 200, 100, 50));
        send_item(mk_pixel(31, 255, 255, 255));
        send_item(mk_pixel(255, 255, 255, 255));
        send_item(mk_pixel(1, 1, 1, 1));

        // Negative sums read as a huge peak and clamp the colors to zero.
        load_config(MODE_INTENSITY, 3'd2, -256, 256, 256, 256);
        send_item(mk_pixel(100, 10, 20, 30));
        send_item(mk_pixel(100, 0, 0, 0));

        // Count lowered after three sources: the next source ends the pixel.
        load_config(MODE_RAW, 3'd4, 256, 256, 256, 256);
        send_item(mk_pixel(10, 20, 30, 40));
        send_item(mk_pixel(50, 60, 70, 80));
        send_item(mk_pixel(90, 100, 110, 120));
        drain_and_settle();
        write_cfg(REG_COUNT, CFG_DATA_W'(3'd2));
        send_item(mk_pixel(130, 140, 150, 160));

        // Mode switched between the two sources of one pixel.
        load_config(MODE_RAW, 3'd2, 300, -100, 256, 256);
        send_item(mk_pixel(40, 80, 120, 160));
        drain_and_settle();
        write_cfg(REG_MODE, CFG_DATA_W'(MODE_INTENSITY));
        send_item(mk_pixel(200, 150, 100, 50));

        // Random settings, each followed by a run of random sources. Phases often
        // end mid-pixel, so new settings also land on partly summed pixels.
        phase = 0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            no_idle = (phase == 4 || phase == 5);
            if (phase % 5 == 3) begin
                // Only the count changes, keeping any partial sums in place.
                drain_and_settle();
                write_cfg(REG_COUNT, CFG_DATA_W'($urandom_range(0, 7)));
            end else begin
                load_config(1'($urandom_range(0, 1)), COUNT_W'($urandom_range(0, 7)),
                            random_factor(), random_factor(), random_factor(),
                            random_factor());
            end
            n = $urandom_range(60, 220);
            send_random(n);
            sent += n;
            phase++;
        end
        no_idle = 1'b0;

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES)
            @(negedge clk);

        $display("Covered %0d source items under %0d settings and %0d register writes.",
                 sb.sources_taken, settings_used, reg_writes);
        $display("Checked %0d mixed pixels, %0d of them in intensity mode.",
                 sb.pixels_checked, sb.intensity_pixels);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("weighted_pixel_mix_tb: PASS");
        else
            $display("weighted_pixel_mix_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/wpm_pkg.sv
hdl/wpm_front.sv
hdl/wpm_queue.sv
hdl/wpm_back.sv
hdl/weighted_pixel_mix.sv
tb/sv/weighted_pixel_mix_tb.sv
